[hdl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/csf_pkg.sv]
package csf_pkg;

    localparam int MAX_PAIRS_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int SIM_W          = 16;
    localparam int ST_W           = 2;
    localparam int QDEPTH         = 2;
    // quotient 2^32*dot^2/(nx*ny) never exceeds 2^32
    localparam int QW             = 33;
    localparam int SW             = QW + 1;
    localparam int SQ_STEPS       = SW / 2;
    localparam int KW             = 17;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

    localparam logic [SIM_W-1:0] SIM_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_M,
        S_MUL_P,
        S_DIV,
        S_SQRT,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qflags;

endpackage

[hdl/csf_front.sv]
module csf_front #(
    parameter int MAX_PAIRS  = 1024,
    parameter int DATA_WIDTH = 16,
    parameter int DOT_W      = 42,
    parameter int NORM_W     = 41
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [DATA_WIDTH-1:0]  i_x,
    input  logic signed [DATA_WIDTH-1:0]  i_y,
    input  logic                          i_last,
    input  csf_pkg::t_qflags              i_qflags,
    output logic                          o_ready,
    output logic                          o_push,
    output logic signed [DOT_W-1:0]       o_dot,
    output logic [NORM_W-1:0]             o_nx,
    output logic [NORM_W-1:0]             o_ny,
    output logic [csf_pkg::ST_W-1:0]      o_status
);
    import csf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int PROD_W = 2 * DATA_WIDTH;

    logic signed [DOT_W-1:0]  r_dot, n_dot;
    logic [NORM_W-1:0]        r_nx, n_nx, r_ny, n_ny;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_ovf, n_ovf;
    logic signed [PROD_W-1:0] w_xy, w_xx, w_yy;
    logic                     w_acc;

    assign w_xy    = i_x * i_y;
    assign w_xx    = i_x * i_x;
    assign w_yy    = i_y * i_y;
    assign o_ready = !i_qflags.full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_dot = r_dot;
        n_nx  = r_nx;
        n_ny  = r_ny;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (r_cnt == CNT_W'(MAX_PAIRS)) begin
            n_ovf = 1'b1;
        end else begin
            n_dot = r_dot + DOT_W'(w_xy);
            n_nx  = r_nx + NORM_W'(unsigned'(w_xx));
            n_ny  = r_ny + NORM_W'(unsigned'(w_yy));
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    assign o_push = w_acc && i_last;
    assign o_dot  = n_dot;
    assign o_nx   = n_nx;
    assign o_ny   = n_ny;

    always_comb begin
        if (n_ovf) begin
            o_status = ST_OVF;
        end else if (n_nx == '0 || n_ny == '0) begin
            o_status = ST_ZERO;
        end else begin
            o_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_nx  <= '0;
            r_ny  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_acc) begin
            if (i_last) begin
                r_dot <= '0;
                r_nx  <= '0;
                r_ny  <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_dot <= n_dot;
                r_nx  <= n_nx;
                r_ny  <= n_ny;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

[hdl/csf_queue.sv]
module csf_queue #(
    parameter int W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output csf_pkg::t_qflags o_qflags
);
    import csf_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    logic [W-1:0]          r_mem [QDEPTH];
    logic [PW-1:0]         r_wp, r_rp;
    logic [$clog2(QDEPTH+1)-1:0] r_cnt;

    assign o_data         = r_mem[r_rp];
    assign o_qflags.empty = (r_cnt == '0);
    assign o_qflags.full  = (r_cnt == ($clog2(QDEPTH+1))'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hdl/csf_back.sv]
module csf_back #(
    parameter int DOT_W  = 42,
    parameter int NORM_W = 41
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csf_pkg::t_qflags              i_qflags,
    input  logic signed [DOT_W-1:0]       i_dot,
    input  logic [NORM_W-1:0]             i_nx,
    input  logic [NORM_W-1:0]             i_ny,
    input  logic [csf_pkg::ST_W-1:0]      i_status,
    output logic                          o_pop,
    input  logic                          i_tready,
    output logic                          o_tvalid,
    output logic [csf_pkg::SIM_W-1:0]     o_sim,
    output logic [csf_pkg::ST_W-1:0]      o_status
);
    import csf_pkg::*;

    `include "assert_macros.svh"

    localparam int MW  = 2 * DOT_W;
    localparam int CW  = $clog2(MW + 1);

    t_state            r_state, n_state;
    logic              r_neg;
    logic [NORM_W-1:0] r_ny;
    logic [MW-1:0]     r_mcand, r_mplier, r_acc, r_m, r_p;
    logic [MW:0]       r_rem;
    logic [QW-1:0]     r_q;
    logic [SW-1:0]     r_op, r_res, r_one;
    logic [CW-1:0]     r_cnt;
    logic [ST_W-1:0]   r_st, r_ost;
    logic [SIM_W-1:0]  r_hold, r_sim;
    logic              r_ov;

    logic [MW-1:0]     w_acc_n;
    logic [MW:0]       w_rsh;
    logic              w_ge;
    logic [SW-1:0]     w_sum;
    logic [KW-1:0]     w_k;
    logic              w_last;
    logic [DOT_W-1:0]  w_mag;

    assign w_acc_n = r_mplier[0] ? r_acc + r_mcand : r_acc;
    assign w_rsh   = {r_rem[MW-1:0], (r_cnt == '0) ? r_m[0] : 1'b0};
    assign w_ge    = (w_rsh >= {1'b0, r_p});
    assign w_sum   = r_res + r_one;
    assign w_k     = KW'((r_res + SW'(1)) >> 1);
    assign w_mag   = i_dot[DOT_W-1] ? DOT_W'(-i_dot) : DOT_W'(i_dot);

    assign o_pop    = (r_state == S_IDLE) && !i_qflags.empty;
    assign o_tvalid = r_ov;
    assign o_sim    = r_sim;
    assign o_status = r_ost;

    always_comb begin
        n_state = r_state;
        w_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_qflags.empty) begin
                    n_state = (i_status == ST_OK) ? S_MUL_M : S_OUT;
                end
            end
            S_MUL_M: begin
                w_last = (r_cnt == CW'(DOT_W - 1));
                if (w_last) n_state = S_MUL_P;
            end
            S_MUL_P: begin
                w_last = (r_cnt == CW'(NORM_W - 1));
                if (w_last) n_state = S_DIV;
            end
            S_DIV: begin
                w_last = (r_cnt == CW'(QW - 1));
                if (w_last) n_state = S_SQRT;
            end
            S_SQRT: begin
                w_last = (r_cnt == CW'(SQ_STEPS - 1));
                if (w_last) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_tready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_ov || i_tready)) begin
                r_ov <= 1'b1;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= (r_state == S_IDLE || w_last) ? '0 : r_cnt + CW'(1);
        case (r_state)
            S_IDLE: begin
                r_neg    <= i_dot[DOT_W-1];
                r_st     <= i_status;
                r_ny     <= i_ny;
                r_hold   <= '0;
                r_acc    <= '0;
                r_mcand  <= MW'(w_mag);
                r_mplier <= MW'(w_mag);
                r_p      <= MW'(i_nx);
            end
            S_MUL_M, S_MUL_P: begin
                if (w_last && r_state == S_MUL_M) begin
                    r_m      <= w_acc_n;
                    r_acc    <= '0;
                    r_mcand  <= r_p;
                    r_mplier <= MW'(r_ny);
                end else begin
                    r_acc    <= w_acc_n;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (w_last) begin
                        r_p   <= w_acc_n;
                        r_rem <= (MW + 1)'(r_m >> 1);
                    end
                end
            end
            S_DIV: begin
                r_rem <= w_ge ? w_rsh - {1'b0, r_p} : w_rsh;
                r_q   <= {r_q[QW-2:0], w_ge};
                if (w_last) begin
                    r_op  <= SW'({r_q[QW-2:0], w_ge});
                    r_res <= '0;
                    r_one <= SW'(1) << (SW - 2);
                end
            end
            S_SQRT: begin
                if (r_op >= w_sum) begin
                    r_op  <= r_op - w_sum;
                    r_res <= (r_res >> 1) + r_one;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_one <= r_one >> 2;
            end
            S_FIN: begin
                if (r_neg) begin
                    r_hold <= SIM_W'(KW'(0) - w_k);
                end else begin
                    r_hold <= (w_k > KW'(SIM_MAX)) ? SIM_MAX : SIM_W'(w_k);
                end
            end
            S_OUT: begin
                if (!r_ov || i_tready) begin
                    r_sim <= (r_st == ST_OK) ? r_hold : '0;
                    r_ost <= r_st;
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_IMPLIES(a_fault_zero_sim, r_ov && (r_ost != ST_OK), r_sim == '0)
    `ASSERT_NEXT(a_pop_leaves_idle, o_pop, r_state != S_IDLE)
    `ASSERT_IMPLIES(a_root_bound, r_state == S_FIN, r_res <= (SW'(1) << 16))

endmodule

[hdl/cosine_similarity_fixed_unit.sv]
// Streaming cosine similarity. Each slave transaction carries one (x, y) element pair;
// tlast marks the final pair of a vector. Pairs are taken one per clock and summed into
// the dot product and both squared norms. The final pair queues a job (two deep) for the
// back end, which emits dot/sqrt(|x|^2*|y|^2) as a rounded, saturated Q1.15 value plus a
// status (0 ok, 1 zero norm, 2 more than MAX_PAIRS pairs; similarity 0 on a fault).
// The back end takes one vector at a time: a shift-add multiplier forms dot^2 and the
// norm product one bit per cycle, a restoring divider yields one quotient bit per cycle and
// a digit-by-digit root one bit per cycle. Faulted vectors skip the arithmetic and go
// straight to the output. Pairs stall only while two finished vectors wait in the queue.
module cosine_similarity_fixed_unit #(
    parameter int MAX_PAIRS  = csf_pkg::MAX_PAIRS_DEF,
    parameter int DATA_WIDTH = csf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // x_value, y_value
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // similarity
    output logic [csf_pkg::SIM_W-1:0]                   m_axis_tdata,
    // status
    output logic [csf_pkg::ST_W-1:0]                    m_axis_tuser
);
    import csf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int DOT_W  = 2 * DATA_WIDTH + CNT_W;
    localparam int NORM_W = 2 * DATA_WIDTH + CNT_W - 1;
    localparam int JW     = ST_W + 2 * NORM_W + DOT_W;

    t_qflags                 w_qf;
    logic                    w_push, w_pop;
    logic signed [DOT_W-1:0] w_f_dot;
    logic [NORM_W-1:0]       w_f_nx, w_f_ny;
    logic [ST_W-1:0]         w_f_st;
    logic [JW-1:0]           w_qout;

    csf_front #(
        .MAX_PAIRS (MAX_PAIRS),
        .DATA_WIDTH(DATA_WIDTH),
        .DOT_W     (DOT_W),
        .NORM_W    (NORM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_x      (signed'(s_axis_tdata[DATA_WIDTH-1:0])),
        .i_y      (signed'(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
        .i_last   (s_axis_tlast),
        .i_qflags (w_qf),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_dot    (w_f_dot),
        .o_nx     (w_f_nx),
        .o_ny     (w_f_ny),
        .o_status (w_f_st)
    );

    csf_queue #(
        .W(JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({w_f_st, w_f_ny, w_f_nx, w_f_dot}),
        .i_pop    (w_pop),
        .o_data   (w_qout),
        .o_qflags (w_qf)
    );

    csf_back #(
        .DOT_W (DOT_W),
        .NORM_W(NORM_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qflags (w_qf),
        .i_dot    (signed'(w_qout[DOT_W-1:0])),
        .i_nx     (w_qout[DOT_W+NORM_W-1:DOT_W]),
        .i_ny     (w_qout[DOT_W+2*NORM_W-1:DOT_W+NORM_W]),
        .i_status (w_qout[JW-1:DOT_W+2*NORM_W]),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_sim    (m_axis_tdata),
        .o_status (m_axis_tuser)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import csf_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } t_pair;

    typedef struct {
        logic [SIM_W-1:0] sim;
        logic [ST_W-1:0]  st;
    } t_score;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [SIM_W-1:0]  m_axis_tdata;
    logic [ST_W-1:0]   m_axis_tuser;

    cosine_similarity_fixed_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    t_pair       pending_pairs[$];
    t_score      expected_scores[$];
    t_pair       cur_pair;
    int          send_gap;
    int          errors;
    int          vectors_seen;
    int          statuses[3];
    bit          calm;
    longint      dot_acc;
    longint      xnorm_acc;
    longint      ynorm_acc;
    int          pairs_taken;
    bit          too_many;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // largest k with (2k-1)^2*nx*ny <= (65536*mag)^2
    function automatic logic [16:0] cosine_mag(longint mag, longint nx, longint ny);
        logic [127:0] rhs, lhs, odd;
        int lo, hi, mid;
        rhs = 128'(mag) << 16;
        rhs = rhs * rhs;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 128'(2 * mid - 1);
            lhs = odd * odd * 128'(nx) * 128'(ny);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[16:0];
    endfunction

    task automatic accumulate_pair(t_pair p);
        t_score s;
        logic [16:0] k;
        if (pairs_taken >= MAX_PAIRS_DEF) begin
            too_many = 1;
        end else begin
            dot_acc   += longint'(p.x) * longint'(p.y);
            xnorm_acc += longint'(p.x) * longint'(p.x);
            ynorm_acc += longint'(p.y) * longint'(p.y);
            pairs_taken++;
        end
        if (!p.last) return;
        s.sim = '0;
        s.st  = ST_OK;
        if (too_many) begin
            s.st = ST_OVF;
        end else if (xnorm_acc == 0 || ynorm_acc == 0) begin
            s.st = ST_ZERO;
        end else if (dot_acc < 0) begin
            k = cosine_mag(-dot_acc, xnorm_acc, ynorm_acc);
            s.sim = 16'(17'd65536 - k);
        end else begin
            k = cosine_mag(dot_acc, xnorm_acc, ynorm_acc);
            s.sim = (k > 17'd32767) ? SIM_MAX : k[15:0];
        end
        expected_scores.push_back(s);
        dot_acc = 0;
        xnorm_acc = 0;
        ynorm_acc = 0;
        pairs_taken = 0;
        too_many = 0;
    endtask

    task automatic add_pair(int x, int y, bit last);
        t_pair p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    task automatic add_random_vector(int len);
        int kind, scale, x, y;
        kind = $urandom_range(0, 5);
        scale = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
            if (scale == 0) begin
                x = x >>> 12;
                y = y >>> 12;
            end
            case (kind)
                0: y = x;
                1: y = -x;
                2: if ($urandom_range(0, 3) == 0) x = 0;
                default: ;
            endcase
            add_pair(x, y, i == len - 1);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 0;
            send_gap = 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid) accumulate_pair(cur_pair);
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 0;
            end else if (pending_pairs.size() > 0) begin
                cur_pair = pending_pairs.pop_front();
                s_axis_tdata  <= {cur_pair.y, cur_pair.x};
                s_axis_tlast  <= cur_pair.last;
                s_axis_tvalid <= 1;
                send_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_score e;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                vectors_seen++;
                if (m_axis_tuser < 3) statuses[m_axis_tuser]++;
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected transaction sim=%h status=%0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    e = expected_scores.pop_front();
                    if (e.sim !== m_axis_tdata) begin
                        $display("%0t: similarity expected %h actual %h",
                                 $time, e.sim, m_axis_tdata);
                        errors++;
                    end
                    if (e.st !== m_axis_tuser) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.st, m_axis_tuser);
                        errors++;
                    end
                end
            end
            m_axis_tready <= (pick_gap() == 0);
        end
    end

    always begin
        repeat ($urandom_range(500, 3000)) @(posedge i_clk);
        calm = ~calm;
    end

    initial begin
        int total;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        errors = 0;
        vectors_seen = 0;
        calm = 0;
        dot_acc = 0;
        xnorm_acc = 0;
        ynorm_acc = 0;
        pairs_taken = 0;
        too_many = 0;
        i_rst_n = 0;

        add_pair(-32768, -32768, 1);
        add_pair(-32768, 32767, 1);
        add_pair(32767, 32767, 1);
        add_pair(32767, -32768, 1);
        add_pair(0, 5, 1);
        add_pair(7, 0, 1);
        add_pair(0, 0, 1);
        add_pair(1, 1, 0);
        add_pair(1, -1, 1);
        add_pair(3, 4, 0);
        add_pair(4, -3, 1);
        add_pair(-1, 2, 1);
        add_pair(16'h5555, 16'hAAAA, 0);
        add_pair(16'hAAAA, 16'h5555, 1);
        // one pair past the limit, with zero norms as well
        for (int i = 0; i <= MAX_PAIRS_DEF; i++)
            add_pair(0, 0, i == MAX_PAIRS_DEF);
        total = 0;
        while (total < 200) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            add_random_vector(len);
            total += len;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        wait (pending_pairs.size() == 0 && !s_axis_tvalid);
        wait (expected_scores.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("Checked %0d vectors: %0d ok, %0d zero-norm, %0d over-length",
                 vectors_seen, statuses[0], statuses[1], statuses[2]);
        if (errors == 0 && expected_scores.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
